// File: rtl/wtc_pkg.sv
// Package for the whitespace token classifier.
// Holds token kind codes, number parse phases and character/word helper functions.
// No dependencies.
package wtc_pkg;

  typedef enum logic [4:0] {
    K_FUNC = 5'd0, K_STOP = 5'd1, K_ITER = 5'd2, K_HALT = 5'd3, K_ONCE = 5'd4,
    K_PASS = 5'd5, K_TYPE = 5'd6, K_NULL = 5'd7, K_TRUE = 5'd8,
    K_NULL_EQ = 5'd9, K_FUNC_EQ = 5'd10, K_NUMBER = 5'd11,
    K_ID = 5'd12, K_DOT_ID = 5'd13, K_PID = 5'd14, K_DOT_PID = 5'd15,
    K_TID = 5'd16, K_DOT_TID = 5'd17, K_ID_EQ = 5'd18, K_PID_EQ = 5'd19,
    K_TID_EQ = 5'd20, K_PID_ARROW = 5'd21, K_OTHER = 5'd22
  } kind_e;

  typedef enum logic [2:0] {
    NS_START = 3'd0, NS_SIGN = 3'd1, NS_ZERO = 3'd2, NS_X = 3'd3,
    NS_DEC = 3'd4, NS_OCT = 3'd5, NS_HEX = 3'd6, NS_FAIL = 3'd7
  } num_phase_e;

  // id/pid recognizer states
  localparam logic [1:0] WS_START  = 2'd0;
  localparam logic [1:0] WS_ACCEPT = 2'd1;
  localparam logic [1:0] WS_DEAD   = 2'd2;
  // tid recognizer states
  localparam logic [2:0] TS_START  = 3'd0;
  localparam logic [2:0] TS_LOWER  = 3'd1;
  localparam logic [2:0] TS_UNDER  = 3'd2;
  localparam logic [2:0] TS_ACCEPT = 3'd3;
  localparam logic [2:0] TS_DEAD   = 3'd4;

  // Status of the number parser as seen by the classifier
  typedef struct packed {
    logic        is_num;
    logic [63:0] value;
  } num_res_t;

  function automatic logic is_lower(input logic [7:0] c);
    return c >= 8'h61 && c <= 8'h7a;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5a;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_lower(c) || is_upper(c) || is_digit(c);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return c == 8'h00 || c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // Step an id (upper_first = 0) or pid (upper_first = 1) recognizer
  function automatic logic [1:0] word_step(input logic upper_first, input logic [1:0] s,
                                           input logic [7:0] c);
    logic [1:0] r;
    r = WS_DEAD;
    if (s == WS_START) begin
      r = (upper_first ? is_upper(c) : is_lower(c)) ? WS_ACCEPT : WS_DEAD;
    end else if (s == WS_ACCEPT) begin
      r = is_alnum(c) ? WS_ACCEPT : WS_DEAD;
    end
    return r;
  endfunction

  // Step the tid recognizer
  function automatic logic [2:0] tid_step(input logic [2:0] s, input logic [7:0] c);
    logic [2:0] r;
    r = TS_DEAD;
    case (s)
      TS_START:  r = is_lower(c) ? TS_LOWER : TS_DEAD;
      TS_LOWER:  r = is_lower(c) ? TS_LOWER : ((c == 8'h5f) ? TS_UNDER : TS_DEAD);
      TS_UNDER:  r = is_upper(c) ? TS_ACCEPT : TS_DEAD;
      TS_ACCEPT: r = is_alnum(c) ? TS_ACCEPT : TS_DEAD;
      default:   r = TS_DEAD;
    endcase
    return r;
  endfunction

  // Keyword texts, first character in the low byte
  localparam logic [39:0] KW_FUNC    = 40'h00636e7566;
  localparam logic [39:0] KW_STOP    = 40'h00706f7473;
  localparam logic [39:0] KW_ITER    = 40'h0072657469;
  localparam logic [39:0] KW_HALT    = 40'h00746c6168;
  localparam logic [39:0] KW_ONCE    = 40'h0065636e6f;
  localparam logic [39:0] KW_PASS    = 40'h0073736170;
  localparam logic [39:0] KW_TYPE    = 40'h0065707974;
  localparam logic [39:0] KW_NULL    = 40'h006c6c756e;
  localparam logic [39:0] KW_TRUE    = 40'h0065757274;
  localparam logic [39:0] KW_NULL_EQ = 40'h3d6c6c756e;
  localparam logic [39:0] KW_FUNC_EQ = 40'h3d636e7566;

endpackage

// File: rtl/whitespace_token_classifier.sv
// Top level of the whitespace token classifier.
// Depends on wtc_pkg and wtc_num.
//
// Usage:
//   One source character per request on the input channel (ch_i); a zero
//   byte ends the source. Tokens are runs of characters split at C
//   whitespace or zero. When a separator closes a non-empty token, one
//   request leaves on the output channel: kind, start offset, length and
//   the parsed value for number tokens.
//   The result of a token is registered and becomes valid in the cycle after
//   its closing separator is accepted. Throughput: one character per cycle
//   while in_ready_o is high; the state registers update in a single pass per character.
//   Stall: the result sits in an output register; while it waits, input is
//   still taken unless the waiting result is not taken and a new one is due
//   in the same cycle, in which case in_ready_o drops for that cycle.
//   Reset: offsets, counts and all recognizers return to the start of a new
//   source; the output register empties.
module whitespace_token_classifier import wtc_pkg::*; #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         token_kind_o,
  output logic [31:0]        start_offset_o,
  output logic [31:0]        token_length_o,
  output logic signed [63:0] number_value_o
);

  localparam int CW = (OFFSET_WIDTH < 32) ? OFFSET_WIDTH : 32;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [CW-1:0] pos_q, begin_q, cnt_q;
  logic [39:0]   first_q;
  logic [15:0]   tail_q;
  logic [1:0]    id_q, pid_q, did_q, dpid_q, id1_q, pid1_q, pid2_q;
  logic [2:0]    tid_q, dtid_q, tid1_q;

  logic      in_fire, sep, emit;
  num_res_t  num_res;
  kind_e     kind;
  logic      out_valid_q;

  assign in_fire    = in_valid_i && in_ready_o;
  assign sep        = is_sep(ch_i);
  assign emit       = in_fire && sep && cnt_q != '0;
  // Block only a closing separator while the previous result still waits
  assign in_ready_o = !out_valid_q || out_ready_i || !sep || cnt_q == '0;

  wtc_num u_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_fire && !sep),
    .clear_i (in_fire && sep),
    .ch_i    (ch_i),
    .res_o   (num_res)
  );

  // Classify the open token, first match wins
  always_comb begin
    kind = K_OTHER;
    if (cnt_q == CW'(4) && first_q == KW_FUNC) kind = K_FUNC;
    else if (cnt_q == CW'(4) && first_q == KW_STOP) kind = K_STOP;
    else if (cnt_q == CW'(4) && first_q == KW_ITER) kind = K_ITER;
    else if (cnt_q == CW'(4) && first_q == KW_HALT) kind = K_HALT;
    else if (cnt_q == CW'(4) && first_q == KW_ONCE) kind = K_ONCE;
    else if (cnt_q == CW'(4) && first_q == KW_PASS) kind = K_PASS;
    else if (cnt_q == CW'(4) && first_q == KW_TYPE) kind = K_TYPE;
    else if (cnt_q == CW'(4) && first_q == KW_NULL) kind = K_NULL;
    else if (cnt_q == CW'(4) && first_q == KW_TRUE) kind = K_TRUE;
    else if (cnt_q == CW'(5) && first_q == KW_NULL_EQ) kind = K_NULL_EQ;
    else if (cnt_q == CW'(5) && first_q == KW_FUNC_EQ) kind = K_FUNC_EQ;
    else if (num_res.is_num) kind = K_NUMBER;
    else if (id_q == WS_ACCEPT) kind = K_ID;
    else if (did_q == WS_ACCEPT) kind = K_DOT_ID;
    else if (pid_q == WS_ACCEPT) kind = K_PID;
    else if (dpid_q == WS_ACCEPT) kind = K_DOT_PID;
    else if (tid_q == TS_ACCEPT) kind = K_TID;
    else if (dtid_q == TS_ACCEPT) kind = K_DOT_TID;
    else if (cnt_q > CW'(1) && tail_q[7:0] == 8'h3d && id1_q == WS_ACCEPT) kind = K_ID_EQ;
    else if (cnt_q > CW'(1) && tail_q[7:0] == 8'h3d && pid1_q == WS_ACCEPT) kind = K_PID_EQ;
    else if (cnt_q > CW'(1) && tail_q[7:0] == 8'h3d && tid1_q == TS_ACCEPT) kind = K_TID_EQ;
    else if (cnt_q > CW'(2) && tail_q == 16'h3c2d && pid2_q == WS_ACCEPT) kind = K_PID_ARROW;
  end

  // Advance token state on each accepted character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      begin_q <= '0;
      cnt_q   <= '0;
      first_q <= '0;
      tail_q  <= '0;
      id_q    <= WS_START; pid_q  <= WS_START; tid_q  <= TS_START;
      did_q   <= WS_START; dpid_q <= WS_START; dtid_q <= TS_START;
      id1_q   <= WS_START; pid1_q <= WS_START; tid1_q <= TS_START;
      pid2_q  <= WS_START;
    end else if (in_fire) begin
      if (sep) begin
        cnt_q   <= '0;
        first_q <= '0;
        tail_q  <= '0;
        id_q    <= WS_START; pid_q  <= WS_START; tid_q  <= TS_START;
        did_q   <= WS_START; dpid_q <= WS_START; dtid_q <= TS_START;
        id1_q   <= WS_START; pid1_q <= WS_START; tid1_q <= TS_START;
        pid2_q  <= WS_START;
        if (ch_i == 8'h00) begin
          pos_q   <= '0;
          begin_q <= '0;
        end else if (pos_q != CNT_MAX) begin
          pos_q <= pos_q + 1'b1;
        end
      end else begin
        if (cnt_q == '0) begin_q <= pos_q;
        if (cnt_q < CW'(5)) first_q[8*cnt_q[2:0] +: 8] <= ch_i;
        tail_q <= {tail_q[7:0], ch_i};
        pid2_q <= pid1_q;
        id1_q  <= id_q;
        pid1_q <= pid_q;
        tid1_q <= tid_q;
        id_q   <= word_step(1'b0, id_q, ch_i);
        pid_q  <= word_step(1'b1, pid_q, ch_i);
        tid_q  <= tid_step(tid_q, ch_i);
        if (cnt_q == '0) begin
          did_q  <= (ch_i == 8'h2e) ? WS_START : WS_DEAD;
          dpid_q <= (ch_i == 8'h2e) ? WS_START : WS_DEAD;
          dtid_q <= (ch_i == 8'h2e) ? TS_START : TS_DEAD;
        end else begin
          did_q  <= word_step(1'b0, did_q, ch_i);
          dpid_q <= word_step(1'b1, dpid_q, ch_i);
          dtid_q <= tid_step(dtid_q, ch_i);
        end
        if (cnt_q != CNT_MAX) cnt_q <= cnt_q + 1'b1;
        if (pos_q != CNT_MAX) pos_q <= pos_q + 1'b1;
      end
    end
  end

  // Hold result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      token_kind_o   <= kind;
      start_offset_o <= 32'(begin_q);
      token_length_o <= 32'(cnt_q);
      number_value_o <= (kind == K_NUMBER) ? num_res.value : 64'd0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o) else $error("closed token produced no result");
  a_sep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && sep |=> cnt_q == '0) else $error("token count not cleared");
  a_eos_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && ch_i == 8'h00 |=> pos_q == '0) else $error("position not reset at end");
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != K_NUMBER |-> number_value_o == 64'd0)
    else $error("value set on non-number token");
`endif

endmodule

// File: rtl/wtc_num.sv
// Saturating signed integer parser with sign and base prefix.
// Depends on wtc_pkg.
module wtc_num import wtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       clear_i,
  input  logic [7:0] ch_i,
  output num_res_t   res_o
);

  num_phase_e  phase_q, phase_d;
  logic        neg_q, neg_d;
  logic        over_q, over_d;
  logic [63:0] accum_q, accum_d;

  logic        add_en;
  logic [1:0]  base_sel; // 0 decimal, 1 octal, 2 hex
  logic [3:0]  digit;
  logic [3:0]  hex_d;
  logic        hex_ok;
  logic [67:0] prod;
  logic [67:0] sum;

  // Decode hex digit value
  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (is_digit(ch_i)) begin
      hex_d = 4'(ch_i - 8'h30);
    end else if (ch_i >= 8'h61 && ch_i <= 8'h66) begin
      hex_d = 4'(ch_i - 8'h57);
    end else if (ch_i >= 8'h41 && ch_i <= 8'h46) begin
      hex_d = 4'(ch_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Advance parse phase
  always_comb begin
    logic is_oct;
    is_oct   = ch_i >= 8'h30 && ch_i <= 8'h37;
    phase_d  = phase_q;
    neg_d    = neg_q;
    add_en   = 1'b0;
    base_sel = 2'd0;
    digit    = hex_d;
    case (phase_q)
      NS_START, NS_SIGN: begin
        if (phase_q == NS_START && (ch_i == 8'h2b || ch_i == 8'h2d)) begin
          neg_d   = ch_i == 8'h2d;
          phase_d = NS_SIGN;
        end else if (ch_i == 8'h30) begin
          phase_d = NS_ZERO;
        end else if (is_digit(ch_i)) begin
          phase_d = NS_DEC;
          add_en  = 1'b1;
        end else begin
          phase_d = NS_FAIL;
        end
      end
      NS_ZERO: begin
        if (ch_i == 8'h78 || ch_i == 8'h58) begin
          phase_d = NS_X;
        end else if (is_oct) begin
          phase_d  = NS_OCT;
          add_en   = 1'b1;
          base_sel = 2'd1;
        end else begin
          phase_d = NS_FAIL;
        end
      end
      NS_X, NS_HEX: begin
        if (hex_ok) begin
          phase_d  = NS_HEX;
          add_en   = 1'b1;
          base_sel = 2'd2;
        end else begin
          phase_d = NS_FAIL;
        end
      end
      NS_DEC: begin
        if (is_digit(ch_i)) add_en = 1'b1;
        else phase_d = NS_FAIL;
      end
      NS_OCT: begin
        base_sel = 2'd1;
        if (is_oct) add_en = 1'b1;
        else phase_d = NS_FAIL;
      end
      default: phase_d = NS_FAIL;
    endcase
  end

  // Multiply-accumulate by shifts; flag overflow past 2^63
  always_comb begin
    case (base_sel)
      2'd1:    prod = {4'd0, accum_q} << 3;
      2'd2:    prod = {4'd0, accum_q} << 4;
      default: prod = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1);
    endcase
    sum     = prod + {64'd0, digit};
    over_d  = over_q;
    accum_d = accum_q;
    if (add_en && !over_q) begin
      accum_d = sum[63:0];
      if (sum[67:64] != 4'd0 || sum[63:0] > 64'h8000_0000_0000_0000) over_d = 1'b1;
    end
  end

  // Hold or clear parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= NS_START;
      neg_q   <= 1'b0;
      over_q  <= 1'b0;
      accum_q <= 64'd0;
    end else if (clear_i) begin
      phase_q <= NS_START;
      neg_q   <= 1'b0;
      over_q  <= 1'b0;
      accum_q <= 64'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      over_q  <= over_d;
      accum_q <= accum_d;
    end
  end

  // Apply sign and saturation
  always_comb begin
    res_o.is_num = phase_q == NS_ZERO || phase_q == NS_DEC ||
                   phase_q == NS_OCT || phase_q == NS_HEX;
    if (neg_q) begin
      res_o.value = over_q ? 64'h8000_0000_0000_0000 : (64'd0 - accum_q);
    end else if (over_q || accum_q[63]) begin
      res_o.value = 64'h7fff_ffff_ffff_ffff;
    end else begin
      res_o.value = accum_q;
    end
  end

endmodule

// File: test/wtc_checker.sv
// Checker for the whitespace token classifier: watches both channels,
// predicts each token result from the accepted characters and compares.
// Depends on wtc_pkg for kind codes, parse phases and keyword texts.
`timescale 1ns / 100ps
module wtc_checker import wtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         ch_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [4:0]         token_kind_i,
  input  logic [31:0]        start_offset_i,
  input  logic [31:0]        token_length_i,
  input  logic signed [63:0] number_value_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [63:0] value;
  } token_res_t;

  token_res_t token_q[$];

  // Predictor state
  logic [31:0] pos, tok_start, tok_len;
  logic [39:0] head_bytes;
  logic [15:0] tail_bytes;
  logic [63:0] accum;
  num_phase_e  phase;
  logic        neg, over;
  logic [2:0]  w_now[3], w_dot[3], w_h1[3], w_h2[3];

  function automatic logic lc(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction
  function automatic logic uc(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction
  function automatic logic dg(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic an(input logic [7:0] c);
    return lc(c) || uc(c) || dg(c);
  endfunction

  // Word class 0 id, 1 pid, 2 tid
  function automatic logic [2:0] dead_state(input int cls);
    return (cls == 2) ? TS_DEAD : {1'b0, WS_DEAD};
  endfunction

  function automatic logic is_accept(input int cls, input logic [2:0] s);
    return (cls == 2) ? (s == TS_ACCEPT) : (s == {1'b0, WS_ACCEPT});
  endfunction

  function automatic logic [2:0] class_next(input int cls, input logic [2:0] s,
                                            input logic [7:0] c);
    logic [2:0] r;
    r = dead_state(cls);
    if (cls != 2) begin
      if (s == {1'b0, WS_START}) begin
        r = ((cls == 0) ? lc(c) : uc(c)) ? {1'b0, WS_ACCEPT} : {1'b0, WS_DEAD};
      end else if (s == {1'b0, WS_ACCEPT}) begin
        r = an(c) ? {1'b0, WS_ACCEPT} : {1'b0, WS_DEAD};
      end
    end else begin
      case (s)
        TS_START:  r = lc(c) ? TS_LOWER : TS_DEAD;
        TS_LOWER:  r = lc(c) ? TS_LOWER : ((c == "_") ? TS_UNDER : TS_DEAD);
        TS_UNDER:  r = uc(c) ? TS_ACCEPT : TS_DEAD;
        TS_ACCEPT: r = an(c) ? TS_ACCEPT : TS_DEAD;
        default:   r = TS_DEAD;
      endcase
    end
    return r;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (dg(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  task automatic clear_token();
    tok_len = 0;
    head_bytes = 0;
    tail_bytes = 0;
    accum = 0;
    phase = NS_START;
    neg = 0;
    over = 0;
    for (int k = 0; k < 3; k++) begin
      w_now[k] = 0; w_dot[k] = 0; w_h1[k] = 0; w_h2[k] = 0;
    end
  endtask

  // Accumulate one digit, saturating into the overflow flag
  task automatic add_digit(input int base, input int d);
    logic [63:0] lim;
    lim = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(base);
    if (!over) begin
      if (accum > lim) over = 1;
      else begin
        accum = accum * 64'(base) + 64'(d);
        if (accum > MIN_NEG) over = 1;
      end
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    int  h;
    logic done;
    h = hex_digit(c);
    done = 0;
    if (phase == NS_START && (c == "+" || c == "-")) begin
      neg = (c == "-");
      phase = NS_SIGN;
      done = 1;
    end else if (phase == NS_START || phase == NS_SIGN) begin
      if (c == "0") begin
        phase = NS_ZERO; done = 1;
      end else if (dg(c)) begin
        phase = NS_DEC; add_digit(10, c - "0"); done = 1;
      end
    end else if (phase == NS_ZERO) begin
      if (c == "x" || c == "X") begin
        phase = NS_X; done = 1;
      end else if (c >= "0" && c <= "7") begin
        phase = NS_OCT; add_digit(8, c - "0"); done = 1;
      end
    end else if (phase == NS_X || phase == NS_HEX) begin
      if (h >= 0) begin
        phase = NS_HEX; add_digit(16, h); done = 1;
      end
    end else if (phase == NS_DEC) begin
      if (dg(c)) begin
        add_digit(10, c - "0"); done = 1;
      end
    end else if (phase == NS_OCT) begin
      if (c >= "0" && c <= "7") begin
        add_digit(8, c - "0"); done = 1;
      end
    end
    if (!done) phase = NS_FAIL;
  endtask

  function automatic token_res_t classify_token();
    token_res_t r;
    logic [39:0] kw4[9];
    r.start = tok_start;
    r.len = tok_len;
    r.value = 0;
    kw4 = '{KW_FUNC, KW_STOP, KW_ITER, KW_HALT, KW_ONCE, KW_PASS, KW_TYPE, KW_NULL, KW_TRUE};
    if (tok_len == 4) begin
      for (int i = 0; i < 9; i++) begin
        if (head_bytes == kw4[i]) begin
          r.kind = 5'(K_FUNC + i);
          return r;
        end
      end
    end
    if (tok_len == 5 && head_bytes == KW_NULL_EQ) begin
      r.kind = K_NULL_EQ; return r;
    end
    if (tok_len == 5 && head_bytes == KW_FUNC_EQ) begin
      r.kind = K_FUNC_EQ; return r;
    end
    if (phase == NS_ZERO || phase == NS_DEC || phase == NS_OCT || phase == NS_HEX) begin
      r.kind = K_NUMBER;
      if (neg) r.value = over ? MIN_NEG : (64'd0 - accum);
      else r.value = (over || accum > MAX_POS) ? MAX_POS : accum;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      if (is_accept(i, w_now[i])) begin
        r.kind = 5'(K_ID + 2 * i); return r;
      end
      if (is_accept(i, w_dot[i])) begin
        r.kind = 5'(K_DOT_ID + 2 * i); return r;
      end
    end
    if (tok_len > 1 && tail_bytes[7:0] == "=") begin
      for (int i = 0; i < 3; i++) begin
        if (is_accept(i, w_h1[i])) begin
          r.kind = 5'(K_ID_EQ + i); return r;
        end
      end
    end
    if (tok_len > 2 && tail_bytes == {8'h3c, 8'h2d} && is_accept(1, w_h2[1])) begin
      r.kind = K_PID_ARROW; return r;
    end
    r.kind = K_OTHER;
    return r;
  endfunction

  // Advance the predictor by one accepted character
  task automatic take_char(input logic [7:0] c);
    if (c == 0 || c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (tok_len > 0) token_q.push_back(classify_token());
      clear_token();
      if (c == 0) begin
        pos = 0;
        tok_start = 0;
      end else if (pos < CNT_TOP) pos++;
    end else begin
      if (tok_len == 0) tok_start = pos;
      if (tok_len < 5) head_bytes[8*tok_len +: 8] = c;
      tail_bytes = {tail_bytes[7:0], c};
      for (int k = 0; k < 3; k++) begin
        w_h2[k] = w_h1[k];
        w_h1[k] = w_now[k];
        w_now[k] = class_next(k, w_now[k], c);
        if (tok_len == 0) w_dot[k] = (c == ".") ? 3'd0 : dead_state(k);
        else w_dot[k] = class_next(k, w_dot[k], c);
      end
      parse_char(c);
      if (tok_len < CNT_TOP) tok_len++;
      if (pos < CNT_TOP) pos++;
    end
  endtask

  initial begin
    pos = 0;
    tok_start = 0;
    clear_token();
    fail_count_o = 0;
    checked_o = 0;
  end

  assign pending_o = token_q.size();

  // Predict on input requests, compare on output requests
  always @(posedge clk_i) begin
    token_res_t exp_r;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected result kind=%0d start=%0d len=%0d value=%0d", $time,
                   token_kind_i, start_offset_i, token_length_i, number_value_i);
          fail_count_o++;
        end else begin
          exp_r = token_q.pop_front();
          checked_o++;
          if (token_kind_i !== exp_r.kind) begin
            $display("%0t: token_kind expected %0d actual %0d", $time, exp_r.kind,
                     token_kind_i);
            fail_count_o++;
          end
          if (start_offset_i !== exp_r.start) begin
            $display("%0t: start_offset expected %0d actual %0d", $time, exp_r.start,
                     start_offset_i);
            fail_count_o++;
          end
          if (token_length_i !== exp_r.len) begin
            $display("%0t: token_length expected %0d actual %0d", $time, exp_r.len,
                     token_length_i);
            fail_count_o++;
          end
          if (number_value_i !== exp_r.value) begin
            $display("%0t: number_value expected %0d actual %0d", $time,
                     $signed(exp_r.value), number_value_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) take_char(ch_i);
    end
  end

endmodule

// File: test/tb.sv
// Testbench top for the whitespace token classifier: drives characters,
// paces the result channel and gives the verdict.
// Depends on wtc_pkg, whitespace_token_classifier and wtc_checker.
`timescale 1ns / 100ps
module tb;

  logic               clk, rst_n;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic [7:0]         ch;
  logic [4:0]         token_kind;
  logic [31:0]        start_offset, token_length;
  logic signed [63:0] number_value;
  int                 fail_count, pending, checked;
  int                 send_idle, recv_idle, n_chars, stuck;

  whitespace_token_classifier uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .ch_i(ch),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .token_kind_o(token_kind), .start_offset_o(start_offset),
    .token_length_o(token_length), .number_value_o(number_value)
  );

  wtc_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .ch_i(ch),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .token_kind_i(token_kind), .start_offset_i(start_offset),
    .token_length_i(token_length), .number_value_i(number_value),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Pace the result channel
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // End the run when no request moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= 2000) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one character; called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    n_chars++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_sep();
    logic [7:0] seps[7];
    seps = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd0};
    send_char(seps[$urandom_range(0, 6)]);
    if ($urandom_range(0, 3) == 0) send_char(seps[$urandom_range(0, 5)]);
  endtask

  function automatic logic [7:0] rand_alnum();
    case ($urandom_range(0, 2))
      0: return 8'("a" + $urandom_range(0, 25));
      1: return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // Emit one random token of a random shape
  task automatic send_token();
    string kw[11];
    int    n, cls;
    kw = '{"func", "stop", "iter", "halt", "once", "pass", "type", "null", "true",
           "null=", "func="};
    case ($urandom_range(0, 9))
      0, 1: begin
        send_str(kw[$urandom_range(0, 10)]);
        if ($urandom_range(0, 3) == 0) send_char(rand_alnum());
      end
      2, 3, 4: begin
        case ($urandom_range(0, 2))
          0: send_char("+");
          1: send_char("-");
          default: ;
        endcase
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 24) : $urandom_range(0, 6);
        case ($urandom_range(0, 2))
          0: begin
            send_char(8'("1" + $urandom_range(0, 8)));
            repeat (n) send_char(8'("0" + $urandom_range(0, 9)));
          end
          1: begin
            send_char("0");
            send_char($urandom_range(0, 1) ? "x" : "X");
            repeat (n) send_char(8'($urandom_range(0, 1) ? "0" + $urandom_range(0, 9)
                                    : ($urandom_range(0, 1) ? "a" : "A")
                                      + $urandom_range(0, 5)));
          end
          default: begin
            send_char("0");
            repeat (n) send_char(8'("0" + $urandom_range(0, 7)));
            if ($urandom_range(0, 5) == 0) send_char(8'("8" + $urandom_range(0, 1)));
          end
        endcase
      end
      5, 6, 7: begin
        cls = $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) send_char(".");
        if (cls == 1) send_char(8'("A" + $urandom_range(0, 25)));
        else begin
          repeat ($urandom_range(1, 3)) send_char(8'("a" + $urandom_range(0, 25)));
          if (cls == 2) begin
            send_char("_");
            send_char(8'("A" + $urandom_range(0, 25)));
          end
        end
        repeat ($urandom_range(0, 4)) send_char(rand_alnum());
        case ($urandom_range(0, 3))
          0: send_char("=");
          1: send_str("<-");
          default: ;
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(1, 255)));
      end
    endcase
    send_sep();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    ch = 8'd0;
    out_ready = 1'b0;
    stuck = 0;
    n_chars = 0;
    send_idle = 26;
    recv_idle = 54;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: keywords, numbers at the edges, word classes, odd bytes
    send_str("func stop\titer\nhalt\vonce\fpass\rtype  null true null= func= ");
    send_str("0 -0 +7 0x 0X1f 08 017 - + 9223372036854775807 9223372036854775808 ");
    send_str("-9223372036854775808 -9223372036854775809 0xFFFFFFFFFFFFFFFFF ");
    send_str("abc .abc Abc .Abc ab_Cd .ab_Cd x= X= a_B= X<- .x= ..a a<- ");
    send_char(8'hff);
    send_char(8'h80);
    send_char(8'h7f);
    send_char(8'd0);
    send_str("z9");
    send_char(8'd0);

    // Random tokens over three pacing modes
    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 26 : ((m == 1) ? 54 : 0);
      recv_idle = (m == 0) ? 54 : ((m == 1) ? 26 : 0);
      while (n_chars < 250 + 85 * (m + 1)) send_token();
    end
    send_char(8'd0);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d characters; %0d token results compared.", n_chars, checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wtc_pkg.sv
rtl/wtc_num.sv
rtl/whitespace_token_classifier.sv
test/wtc_checker.sv
test/tb.sv
